>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL of the profiler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Base form: a labeled concurrent assertion on the rising clock edge, off during reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   `ASSERT_PROP(lbl, clk, rst, (ante) |-> (cons))

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   `ASSERT_PROP(lbl, clk, rst, (ante) |=> (cons))

`endif

>>> rtl/core/ilp_pkg.sv
// Types and constants of the interval latency profiler.
package ilp_pkg;

   // Field widths of the request and response transfers.
   localparam int OP_W   = 2;
   localparam int DOM_W  = 6;
   localparam int TS_W   = 64;
   localparam int CNT_W  = 32;

   // Request tdata carries domain and timestamp, padded to whole bytes.
   localparam int REQ_FIELDS_W = DOM_W + TS_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_PAD_W    = REQ_TDATA_W - REQ_FIELDS_W;

   // Operation codes carried in the request tuser.
   typedef enum logic [OP_W-1:0] {
      OP_START = 2'd0,
      OP_STOP  = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // Response status codes.
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_UNSTARTED = 1'b1;

   // Per-domain statistics as held in the statistics RAM; min sits in the low bits.
   typedef struct packed {
      logic [CNT_W-1:0] sample_count;
      logic [TS_W-1:0]  total_interval;
      logic [TS_W-1:0]  max_interval;
      logic [TS_W-1:0]  min_interval;
   } stats_type;

   localparam int STATS_W = $bits(stats_type);

   // Response tdata carries elapsed, in_use and the statistics, padded to whole bytes.
   localparam int RSP_FIELDS_W = TS_W + 1 + STATS_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_WRITE
   } state_type;

endpackage

>>> rtl/core/ilp_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module ilp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/interval_latency_profiler_unit.sv
// Top level of the interval latency profiler: sequencer, statistics RAMs and response register.
// Each request passes accept and RAM read, elapsed subtract, then update and write-back.
// The result is loaded into the response register at commit, in the write-back state.
// No new request is taken until the last is written back, for the read-modify-write loop on the RAMs.
// A stalled response holds the sequencer in write-back until the response register frees.
// Synchronous reset clears the used flags at once; RAM contents stay undefined until written.
module interval_latency_profiler_unit #(
   parameter int NUM_DOMAINS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ilp_pkg::REQ_TDATA_W-1:0]  req_tdata,   // domain[5:0], timestamp[69:6], zero pad
   input  logic [ilp_pkg::OP_W-1:0]         req_tuser,   // opcode[1:0]
   // Response channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ilp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // elapsed[63:0], in_use[64],
                                                         // min[128:65], max[192:129],
                                                         // total[256:193], count[288:257], pad
   output logic                             rsp_tuser    // status[0]
);

   import ilp_pkg::*;

   // Memory index width and the number of domains the 6-bit field can reach.
   localparam int IDX_W  = $clog2(NUM_DOMAINS);
   localparam int EXT_W  = IDX_W + DOM_W;
   localparam int FLAG_N = (NUM_DOMAINS < (1 << DOM_W)) ? NUM_DOMAINS : (1 << DOM_W);
   localparam int FLAG_W = $clog2(FLAG_N);

   // Request field unpacking.
   logic [DOM_W-1:0] req_domain;
   logic [TS_W-1:0]  req_timestamp;
   logic [EXT_W-1:0] req_dom_ext;
   logic [IDX_W-1:0] req_midx;
   logic [FLAG_W-1:0] req_fidx;
   logic             req_valid_dom;
   logic             accept;

   assign req_domain    = req_tdata[DOM_W-1:0];
   assign req_timestamp = req_tdata[DOM_W +: TS_W];
   assign req_dom_ext   = {{IDX_W{1'b0}}, req_domain};
   assign req_midx      = req_dom_ext[IDX_W-1:0];
   assign req_fidx      = req_domain[FLAG_W-1:0];
   assign req_valid_dom = req_dom_ext < EXT_W'(NUM_DOMAINS);
   assign accept        = req_tvalid && req_tready;

   // Sequencer and per-request registers.
   state_type         state_ff, state_in;
   op_type            op_ff;
   logic              valid_ff;
   logic              used_ff;
   logic [TS_W-1:0]   ts_ff;
   logic [IDX_W-1:0]  midx_ff;
   logic [FLAG_W-1:0] fidx_ff;
   logic [TS_W-1:0]   elapsed_ff, elapsed_in;
   logic [FLAG_N-1:0] flags_ff, flags_in;
   logic              commit;

   // Events watched by the checks at the end.
   logic              clear_commit;
   logic              start_commit;
   logic              rsp_error;
   logic              rsp_empty;

   // RAM ports.
   logic [TS_W-1:0]    stamp_rd;
   logic [STATS_W-1:0] stats_rd_raw;
   stats_type          stats_rd;
   logic               stamp_we;
   logic               stats_we;
   stats_type          stats_wdata;

   // Response registers.
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      rsp_status_ff, rsp_status_in;
   logic      rsp_in_use_ff, rsp_in_use_in;
   logic [TS_W-1:0] rsp_elapsed_ff, rsp_elapsed_in;
   stats_type rsp_stats_ff, rsp_stats_in;

   // Start stamps and statistics, read on the request transfer.
   ilp_ram #(
      .WIDTH (TS_W),
      .DEPTH (NUM_DOMAINS)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_we),
      .wr_addr (midx_ff),
      .wr_data (ts_ff),
      .rd_en   (accept),
      .rd_addr (req_midx),
      .rd_data (stamp_rd)
   );

   ilp_ram #(
      .WIDTH (STATS_W),
      .DEPTH (NUM_DOMAINS)
   ) u_stats_ram (
      .clock   (clock),
      .wr_en   (stats_we),
      .wr_addr (midx_ff),
      .wr_data (stats_wdata),
      .rd_en   (accept),
      .rd_addr (req_midx),
      .rd_data (stats_rd_raw)
   );

   assign stats_rd = stats_type'(stats_rd_raw);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state, handshake and commit; no request is taken while reset is high.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      commit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Request capture; the used flag is sampled at the transfer.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= op_type'(req_tuser);
         valid_ff <= req_valid_dom;
         used_ff  <= req_valid_dom && flags_ff[req_fidx];
         ts_ff    <= req_timestamp;
         midx_ff  <= req_midx;
         fidx_ff  <= req_fidx;
      end
   end

   // Elapsed time, modulo 2^64.
   assign elapsed_in = ts_ff - stamp_rd;

   always_ff @(posedge clock) begin
      if (state_ff == ST_CALC) begin
         elapsed_ff <= elapsed_in;
      end
   end

   // Statistics update and response fields.
   always_comb begin
      stats_type upd;
      upd.min_interval   = (elapsed_ff < stats_rd.min_interval) ? elapsed_ff
                                                                : stats_rd.min_interval;
      upd.max_interval   = (elapsed_ff > stats_rd.max_interval) ? elapsed_ff
                                                                : stats_rd.max_interval;
      upd.total_interval = stats_rd.total_interval + elapsed_ff;
      upd.sample_count   = stats_rd.sample_count + CNT_W'(1);

      stats_wdata    = upd;
      stamp_we       = 1'b0;
      stats_we       = 1'b0;
      rsp_status_in  = STATUS_OK;
      rsp_elapsed_in = '0;
      rsp_in_use_in  = 1'b0;
      rsp_stats_in   = '0;
      case (op_ff)
         OP_START: begin
            if (valid_ff) begin
               rsp_in_use_in = 1'b1;
               stamp_we      = commit;
               stats_we      = commit && !used_ff;
            end
            stats_wdata.min_interval   = '1;
            stats_wdata.max_interval   = '0;
            stats_wdata.total_interval = '0;
            stats_wdata.sample_count   = '0;
         end
         OP_STOP: begin
            if (used_ff) begin
               rsp_in_use_in  = 1'b1;
               rsp_elapsed_in = elapsed_ff;
               stats_we       = commit;
            end else begin
               rsp_status_in = STATUS_UNSTARTED;
            end
         end
         OP_READ: begin
            if (used_ff) begin
               rsp_in_use_in = 1'b1;
               rsp_stats_in  = stats_rd;
            end
         end
         OP_CLEAR: begin
            rsp_in_use_in = 1'b0;
         end
         default: begin
            rsp_in_use_in = 1'b0;
         end
      endcase
   end

   // Used flags: start sets one, clear-all drops them all.
   always_comb begin
      flags_in = flags_ff;
      if (commit) begin
         if (op_ff == OP_CLEAR) begin
            flags_in = '0;
         end else if (op_ff == OP_START && valid_ff) begin
            flags_in[fidx_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   // Response register: loads on commit, drains on the response transfer.
   assign rsp_tvalid_in = commit || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_elapsed_ff <= rsp_elapsed_in;
         rsp_in_use_ff  <= rsp_in_use_in;
         rsp_stats_ff   <= rsp_stats_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_stats_ff, rsp_in_use_ff, rsp_elapsed_ff};

   // Checks on the sequencer and the response contents.
   assign clear_commit = commit && (op_ff == OP_CLEAR);
   assign start_commit = commit && (op_ff == OP_START) && valid_ff;
   assign rsp_error    = rsp_tvalid_ff && (rsp_status_ff == STATUS_UNSTARTED);
   assign rsp_empty    = !rsp_in_use_ff && (rsp_elapsed_ff == '0);

`include "assert_macros.svh"

   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, commit, (!rsp_tvalid_ff || rsp_tready))
   `ASSERT_NEXT(a_clear_drops_flags, clock, reset, clear_commit, (flags_ff == '0))
   `ASSERT_NEXT(a_start_sets_flag, clock, reset, start_commit, flags_ff[fidx_ff])
   `ASSERT_IMPLIES(a_error_is_empty, clock, reset, rsp_error, rsp_empty)

endmodule

>>> tb/tb_interval_latency_profiler_unit.sv
// Self-checking testbench of the interval latency profiler unit.
`timescale 1ns / 100ps

module tb_interval_latency_profiler_unit;
   import ilp_pkg::*;

   localparam int N_DOM        = 64;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_ITEMS  = 310;

   // Bit offsets of the response fields in tdata.
   localparam int OFS_IN_USE = TS_W;
   localparam int OFS_MIN    = OFS_IN_USE + 1;
   localparam int OFS_MAX    = OFS_MIN + TS_W;
   localparam int OFS_TOTAL  = OFS_MAX + TS_W;
   localparam int OFS_COUNT  = OFS_TOTAL + TS_W;

   // One expected response, field by field.
   typedef struct {
      bit             status;
      bit [TS_W-1:0]  elapsed;
      bit             in_use;
      bit [TS_W-1:0]  min_interval;
      bit [TS_W-1:0]  max_interval;
      bit [TS_W-1:0]  total_interval;
      bit [CNT_W-1:0] sample_count;
   } profile_result;

   // Tracks the per-domain statistics table and the responses it implies.
   class interval_stats_scoreboard;
      bit             used_flag[N_DOM];
      bit [TS_W-1:0]  start_stamp[N_DOM];
      bit [TS_W-1:0]  min_seen[N_DOM];
      bit [TS_W-1:0]  max_seen[N_DOM];
      bit [TS_W-1:0]  total_seen[N_DOM];
      bit [CNT_W-1:0] count_seen[N_DOM];
      profile_result  expected_results[$];
      int             mismatches;

      function new();
         mismatches = 0;
         foreach (used_flag[i]) used_flag[i] = 1'b0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Applies one accepted request to the table and queues its response.
      function void note_request(op_type op, bit [DOM_W-1:0] dom, bit [TS_W-1:0] ts);
         profile_result r;
         bit [TS_W-1:0] el;
         r = '{default: 0};
         case (op)
            OP_START: begin
               if (!used_flag[dom]) begin
                  used_flag[dom]  = 1'b1;
                  min_seen[dom]   = '1;
                  max_seen[dom]   = '0;
                  total_seen[dom] = '0;
                  count_seen[dom] = '0;
               end
               start_stamp[dom] = ts;
               r.in_use = 1'b1;
            end
            OP_STOP: begin
               if (used_flag[dom]) begin
                  el = ts - start_stamp[dom];
                  if (el < min_seen[dom]) min_seen[dom] = el;
                  if (el > max_seen[dom]) max_seen[dom] = el;
                  total_seen[dom] = total_seen[dom] + el;
                  count_seen[dom] = count_seen[dom] + 1'b1;
                  r.elapsed = el;
                  r.in_use  = 1'b1;
               end else begin
                  r.status = STATUS_UNSTARTED;
               end
            end
            OP_READ: begin
               if (used_flag[dom]) begin
                  r.in_use         = 1'b1;
                  r.min_interval   = min_seen[dom];
                  r.max_interval   = max_seen[dom];
                  r.total_interval = total_seen[dom];
                  r.sample_count   = count_seen[dom];
               end
            end
            default: begin
               foreach (used_flag[i]) used_flag[i] = 1'b0;
            end
         endcase
         expected_results.push_back(r);
      endfunction

      function void flag(string field, logic [TS_W-1:0] exp_v, logic [TS_W-1:0] act_v);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected %h, actual %h", $realtime, field,
                     exp_v, act_v);
      endfunction

      // Compares one response transfer against the oldest expectation.
      function void check_response(logic [RSP_TDATA_W-1:0] data, logic user);
         profile_result r;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response transfer with nothing expected: %h", $realtime, data);
            return;
         end
         r = expected_results.pop_front();
         if (user !== r.status) flag("status", r.status, user);
         if (data[TS_W-1:0] !== r.elapsed) flag("elapsed", r.elapsed, data[TS_W-1:0]);
         if (data[OFS_IN_USE] !== r.in_use) flag("in_use", r.in_use, data[OFS_IN_USE]);
         if (data[OFS_MIN +: TS_W] !== r.min_interval)
            flag("min_interval", r.min_interval, data[OFS_MIN +: TS_W]);
         if (data[OFS_MAX +: TS_W] !== r.max_interval)
            flag("max_interval", r.max_interval, data[OFS_MAX +: TS_W]);
         if (data[OFS_TOTAL +: TS_W] !== r.total_interval)
            flag("total_interval", r.total_interval, data[OFS_TOTAL +: TS_W]);
         if (data[OFS_COUNT +: CNT_W] !== r.sample_count)
            flag("sample_count", r.sample_count, data[OFS_COUNT +: CNT_W]);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]        req_tuser = OP_START;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;

   interval_stats_scoreboard sb = new();
   int                       send_idle_pct = 0;
   int                       recv_idle_pct = 0;
   int                       quiet_cycles = 0;
   bit [TS_W-1:0]            now_ts = '0;
   int                       pool_base = 0;

   interval_latency_profiler_unit #(.NUM_DOMAINS(N_DOM)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Free-running clock, 10 ns period.
   initial begin
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random, one decision per falling edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Every response transfer is checked as it happens.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tuser);
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Offers one request, entered and left at a falling edge, and waits for its transfer.
   task automatic send_item(op_type op, bit [DOM_W-1:0] dom, bit [TS_W-1:0] ts);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {{REQ_PAD_W{1'b0}}, ts, dom};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      sb.note_request(op, dom, ts);
      @(negedge clock);
   endtask

   // Holds the request side idle until every expected response has arrived.
   task automatic drain_responses();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   function automatic bit [TS_W-1:0] random_ts();
      return {$urandom, $urandom};
   endfunction

   // Mostly a small pool of domains so that starts and stops meet.
   function automatic bit [DOM_W-1:0] pick_domain();
      if ($urandom_range(3) == 0)
         return DOM_W'($urandom_range(N_DOM - 1));
      return DOM_W'(pool_base + $urandom_range(7));
   endfunction

   // Advances the notion of current time by a mostly small step.
   function automatic bit [TS_W-1:0] advance_time();
      int sel;
      sel = $urandom_range(9);
      if (sel < 7)
         now_ts = now_ts + $urandom_range(1000);
      else if (sel < 9)
         now_ts = now_ts + $urandom;
      else
         now_ts = now_ts + random_ts();
      return now_ts;
   endfunction

   // Random traffic: start/stop/read sequences with rare clears and some noise.
   task automatic random_phase(int n_items);
      int sel;
      for (int i = 0; i < n_items; i++) begin
         sel = $urandom_range(99);
         if (sel < 35)
            send_item(OP_START, pick_domain(), advance_time());
         else if (sel < 70)
            send_item(OP_STOP, pick_domain(), advance_time());
         else if (sel < 88)
            send_item(OP_READ, pick_domain(), random_ts());
         else if (sel < 90)
            send_item(OP_CLEAR, pick_domain(), random_ts());
         else
            send_item(op_type'($urandom_range(3)), DOM_W'($urandom_range(N_DOM - 1)),
                      random_ts());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: timestamp extremes, wrapping, restarts and clears.
      send_item(OP_START, 6'd0, '0);
      send_item(OP_STOP,  6'd0, '1);
      send_item(OP_READ,  6'd0, '0);
      // A second stop reuses the old start stamp and wraps the total.
      send_item(OP_STOP,  6'd0, 64'd5);
      send_item(OP_READ,  6'd0, '1);
      // Stop and read on a domain never started.
      send_item(OP_STOP,  6'd63, 64'd1234);
      send_item(OP_READ,  6'd63, '1);
      send_item(OP_START, 6'd63, '1);
      send_item(OP_STOP,  6'd63, '0);
      // A restart of a used domain keeps its statistics.
      send_item(OP_START, 6'd63, 64'd100);
      send_item(OP_STOP,  6'd63, 64'd100);
      send_item(OP_READ,  6'd63, '0);
      send_item(OP_CLEAR, 6'd42, random_ts());
      send_item(OP_READ,  6'd0, '0);
      send_item(OP_STOP,  6'd0, 64'd9);
      send_item(OP_START, 6'd0, 64'd7);
      send_item(OP_READ,  6'd0, '0);
      send_item(OP_STOP,  6'd0, 64'h8000_0000_0000_0007);
      send_item(OP_READ,  6'd0, '0);
      send_item(OP_START, 6'd42, 64'hAAAA_AAAA_AAAA_AAAA);
      send_item(OP_STOP,  6'd42, 64'h5555_5555_5555_5555);
      send_item(OP_READ,  6'd42, '1);
      send_item(OP_CLEAR, 6'd63, '1);
      send_item(OP_READ,  6'd63, '0);

      // Sender rarely idle, receiver often stalled.
      drain_responses();
      send_idle_pct = 14;
      recv_idle_pct = 66;
      pool_base = $urandom_range(N_DOM - 8);
      random_phase(PHASE_ITEMS);

      // Sender often idle, receiver rarely stalled.
      drain_responses();
      send_idle_pct = 66;
      recv_idle_pct = 14;
      pool_base = $urandom_range(N_DOM - 8);
      random_phase(PHASE_ITEMS);

      // Back-to-back traffic on both sides.
      drain_responses();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      pool_base = $urandom_range(N_DOM - 8);
      random_phase(PHASE_ITEMS);

      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
